// ===== hw/rtl/sct_pkg.sv =====
package sct_pkg;

	localparam int POS_BITS = 16;
	localparam int MAX_RES = 4;

	localparam logic [5:0] K_ERROR = 6'd0;
	localparam logic [5:0] K_WORD = 6'd1;
	localparam logic [5:0] K_NUMBER = 6'd2;
	localparam logic [5:0] K_INT = 6'd3;
	localparam logic [5:0] K_KEYWORD = 6'd4;
	localparam logic [5:0] K_LT = 6'd5;
	localparam logic [5:0] K_LE = 6'd6;
	localparam logic [5:0] K_SHL = 6'd7;
	localparam logic [5:0] K_GT = 6'd8;
	localparam logic [5:0] K_GE = 6'd9;
	localparam logic [5:0] K_SHR = 6'd10;
	localparam logic [5:0] K_PLUS = 6'd11;
	localparam logic [5:0] K_INC = 6'd12;
	localparam logic [5:0] K_PLUS_EQ = 6'd13;
	localparam logic [5:0] K_MINUS = 6'd14;
	localparam logic [5:0] K_DEC = 6'd15;
	localparam logic [5:0] K_MINUS_EQ = 6'd16;
	localparam logic [5:0] K_AMP = 6'd17;
	localparam logic [5:0] K_LAND = 6'd18;
	localparam logic [5:0] K_AMP_EQ = 6'd19;
	localparam logic [5:0] K_PIPE = 6'd20;
	localparam logic [5:0] K_LOR = 6'd21;
	localparam logic [5:0] K_PIPE_EQ = 6'd22;
	localparam logic [5:0] K_XOR = 6'd23;
	localparam logic [5:0] K_XOR_EQ = 6'd24;
	localparam logic [5:0] K_STAR = 6'd25;
	localparam logic [5:0] K_STAR_EQ = 6'd26;
	localparam logic [5:0] K_SLASH = 6'd27;
	localparam logic [5:0] K_SLASH_EQ = 6'd28;
	localparam logic [5:0] K_PCT = 6'd29;
	localparam logic [5:0] K_PCT_EQ = 6'd30;
	localparam logic [5:0] K_ASSIGN = 6'd31;
	localparam logic [5:0] K_EQ = 6'd32;
	localparam logic [5:0] K_BANG = 6'd33;
	localparam logic [5:0] K_NE = 6'd34;
	localparam logic [5:0] K_LBRACKET = 6'd35;
	localparam logic [5:0] K_RBRACKET = 6'd36;
	localparam logic [5:0] K_LSQUARE = 6'd37;
	localparam logic [5:0] K_RSQUARE = 6'd38;
	localparam logic [5:0] K_LCURLY = 6'd39;
	localparam logic [5:0] K_RCURLY = 6'd40;
	localparam logic [5:0] K_COLON = 6'd41;
	localparam logic [5:0] K_SEMI = 6'd42;
	localparam logic [5:0] K_COMMA = 6'd43;
	localparam logic [5:0] K_QUESTION = 6'd44;
	localparam logic [5:0] K_HASH = 6'd45;
	localparam logic [5:0] K_AT = 6'd46;
	localparam logic [5:0] K_DOLLAR = 6'd47;
	localparam logic [5:0] K_NOT = 6'd48;
	localparam logic [5:0] K_DOT = 6'd49;
	localparam logic [5:0] K_STRING = 6'd50;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_FF = 8'h0C;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_ZERO = 8'h30;

	typedef struct packed {
		logic        is_record;
		logic [5:0]  kind;
		logic [15:0] line;
		logic [15:0] col;
		logic [7:0]  vbyte;
		logic        last;
	} res_t;

	typedef struct packed {
		logic       found;
		logic [5:0] fail;
		logic [7:0] e1;
		logic [5:0] s1;
		logic       has_e2;
		logic [7:0] e2;
		logic [5:0] s2;
	} op_rule_t;

	typedef struct packed {
		logic       hit;
		logic [5:0] kind;
	} punct_t;

	function automatic op_rule_t op_lookup(input logic [7:0] c);
		op_rule_t r;
		r = '0;
		r.found = 1'b1;
		case (c)
			8'h3C: begin r.fail = K_LT; r.e1 = 8'h3D; r.s1 = K_LE;
				r.has_e2 = 1'b1; r.e2 = 8'h3C; r.s2 = K_SHL; end
			8'h3E: begin r.fail = K_GT; r.e1 = 8'h3D; r.s1 = K_GE;
				r.has_e2 = 1'b1; r.e2 = 8'h3E; r.s2 = K_SHR; end
			8'h2B: begin r.fail = K_PLUS; r.e1 = 8'h2B; r.s1 = K_INC;
				r.has_e2 = 1'b1; r.e2 = 8'h3D; r.s2 = K_PLUS_EQ; end
			8'h2D: begin r.fail = K_MINUS; r.e1 = 8'h2D; r.s1 = K_DEC;
				r.has_e2 = 1'b1; r.e2 = 8'h3D; r.s2 = K_MINUS_EQ; end
			8'h26: begin r.fail = K_AMP; r.e1 = 8'h26; r.s1 = K_LAND;
				r.has_e2 = 1'b1; r.e2 = 8'h3D; r.s2 = K_AMP_EQ; end
			8'h7C: begin r.fail = K_PIPE; r.e1 = 8'h7C; r.s1 = K_LOR;
				r.has_e2 = 1'b1; r.e2 = 8'h3D; r.s2 = K_PIPE_EQ; end
			8'h5E: begin r.fail = K_XOR; r.e1 = 8'h3D; r.s1 = K_XOR_EQ; end
			8'h2A: begin r.fail = K_STAR; r.e1 = 8'h3D; r.s1 = K_STAR_EQ; end
			8'h2F: begin r.fail = K_SLASH; r.e1 = 8'h3D; r.s1 = K_SLASH_EQ; end
			8'h25: begin r.fail = K_PCT; r.e1 = 8'h3D; r.s1 = K_PCT_EQ; end
			8'h3D: begin r.fail = K_ASSIGN; r.e1 = 8'h3D; r.s1 = K_EQ; end
			8'h21: begin r.fail = K_BANG; r.e1 = 8'h3D; r.s1 = K_NE; end
			default: r.found = 1'b0;
		endcase
		return r;
	endfunction

	function automatic punct_t punct_kind(input logic [7:0] c);
		punct_t p;
		p.hit = 1'b1;
		case (c)
			8'h28: p.kind = K_LBRACKET;
			8'h29: p.kind = K_RBRACKET;
			8'h5B: p.kind = K_LSQUARE;
			8'h5D: p.kind = K_RSQUARE;
			8'h7B: p.kind = K_LCURLY;
			8'h7D: p.kind = K_RCURLY;
			8'h3A: p.kind = K_COLON;
			8'h3B: p.kind = K_SEMI;
			8'h2C: p.kind = K_COMMA;
			8'h3F: p.kind = K_QUESTION;
			8'h23: p.kind = K_HASH;
			8'h40: p.kind = K_AT;
			8'h24: p.kind = K_DOLLAR;
			8'h7E: p.kind = K_NOT;
			default: begin p.hit = 1'b0; p.kind = K_ERROR; end
		endcase
		return p;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A))
			|| (c == 8'h5F);
	endfunction

	// keyword texts: const, True, False
	function automatic logic [7:0] kw_char(input int k, input logic [2:0] idx);
		logic [7:0] r;
		r = 8'h00;
		case (k)
			0: case (idx)
				3'd0: r = 8'h63; 3'd1: r = 8'h6F; 3'd2: r = 8'h6E;
				3'd3: r = 8'h73; 3'd4: r = 8'h74; default: r = 8'h00;
			endcase
			1: case (idx)
				3'd0: r = 8'h54; 3'd1: r = 8'h72; 3'd2: r = 8'h75;
				3'd3: r = 8'h65; default: r = 8'h00;
			endcase
			2: case (idx)
				3'd0: r = 8'h46; 3'd1: r = 8'h61; 3'd2: r = 8'h6C;
				3'd3: r = 8'h73; 3'd4: r = 8'h65; default: r = 8'h00;
			endcase
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] kw_len(input int k);
		logic [2:0] r;
		case (k)
			0: r = 3'd5;
			1: r = 3'd4;
			default: r = 3'd5;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] word_cand(input logic [2:0] cand, input logic [2:0] wlen,
			input logic [7:0] c);
		logic [2:0] r;
		r = cand;
		for (int k = 0; k < 3; k++) begin
			if (cand[k] && ((wlen >= kw_len(k)) || (kw_char(k, wlen) != c)))
				r[k] = 1'b0;
		end
		return r;
	endfunction

	function automatic logic is_kw(input logic [2:0] cand, input logic [2:0] wlen);
		logic r;
		r = 1'b0;
		for (int k = 0; k < 3; k++) begin
			if (cand[k] && (kw_len(k) == wlen))
				r = 1'b1;
		end
		return r;
	endfunction

	function automatic logic [15:0] clamp_pos(input logic [POS_BITS-1:0] v);
		logic [32:0] w;
		w = 33'(v);
		if (w > 33'd65535)
			return 16'hFFFF;
		return w[15:0];
	endfunction

	function automatic res_t mk_rec(input logic [5:0] kind, input logic [POS_BITS-1:0] line,
			input logic [POS_BITS-1:0] col);
		res_t r;
		r.is_record = 1'b1;
		r.kind = kind;
		r.line = clamp_pos(line);
		r.col = clamp_pos(col);
		r.vbyte = 8'h00;
		r.last = 1'b0;
		return r;
	endfunction

	function automatic res_t mk_val(input logic [7:0] b);
		res_t r;
		r = '0;
		r.vbyte = b;
		return r;
	endfunction

endpackage

// ===== hw/rtl/source_char_tokenizer.sv =====
// source_char_tokenizer: streaming lexer, one source byte per word on the src channel
// (ch, end_of_source) and one result word per cycle on the tok channel while tok_ready is high.
// Each source byte yields zero to four results, value bytes of tokens and token records
// (kind, line, column) in lexing order. last_of_run marks the final result of a byte.
// The byte is lexed in the cycle it is accepted and its results are registered into a
// four-entry output queue; the first result is visible in the cycle after acceptance.
// Throughput: one byte per cycle while tok_ready is high and each byte yields at most
// one result. A byte yielding several results holds src_ready low while the queue drains,
// one entry per cycle while tok_ready is high. A new byte is taken in the same cycle
// the last queued result is taken. When tok_ready is low the queue holds and src_ready
// stays low while any result is queued.
// end_of_source on a byte closes any open token (an open string closes on that byte)
// and returns the lexer to idle with line and column at zero for the next source.
// Reset (arst_n low) empties the queue, idles the lexer and clears the position.
// Line and column are zero based and saturate at all ones.
module source_char_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	output logic        src_ready,
	input  logic [7:0]  ch,
	input  logic        end_of_source,
	output logic        tok_valid,
	input  logic        tok_ready,
	output logic        is_record,
	output logic [5:0]  token_kind,
	output logic [15:0] line_no,
	output logic [15:0] column_no,
	output logic [7:0]  value_byte,
	output logic        last_of_run
);

	localparam int PB = sct_pkg::POS_BITS;

	localparam logic [2:0] M_IDLE = 3'd0;
	localparam logic [2:0] M_OP   = 3'd1;
	localparam logic [2:0] M_DOT  = 3'd2;
	localparam logic [2:0] M_NUM  = 3'd3;
	localparam logic [2:0] M_WORD = 3'd4;
	localparam logic [2:0] M_STR  = 3'd5;

	localparam logic [PB-1:0] PMAX = '1;

	logic [2:0]    mode_q, mode_n;
	logic [7:0]    pend_q, pend_n;
	logic [PB-1:0] sl_q, sl_n, sc_q, sc_n;
	logic [PB-1:0] line_q, line_n, col_q, col_n;
	logic          dot_q, dot_n;
	logic [2:0]    cand_q, cand_n;
	logic [2:0]    wlen_q, wlen_n;

	sct_pkg::res_t rbuf_q [sct_pkg::MAX_RES];
	sct_pkg::res_t res [sct_pkg::MAX_RES];
	logic [2:0]    cnt_q, n;

	sct_pkg::op_rule_t opp, opc, opf;
	sct_pkg::punct_t   pk;
	logic              do_start;
	logic              accept, pop;

	assign tok_valid = (cnt_q != 3'd0);
	assign pop = tok_valid && tok_ready;
	assign src_ready = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && tok_ready);
	assign accept = src_valid && src_ready;

	assign is_record = rbuf_q[0].is_record;
	assign token_kind = rbuf_q[0].kind;
	assign line_no = rbuf_q[0].line;
	assign column_no = rbuf_q[0].col;
	assign value_byte = rbuf_q[0].vbyte;
	assign last_of_run = rbuf_q[0].last;

	always_comb begin
		for (int i = 0; i < sct_pkg::MAX_RES; i++)
			res[i] = '0;
		n = 3'd0;
		mode_n = mode_q;
		pend_n = pend_q;
		sl_n = sl_q;
		sc_n = sc_q;
		dot_n = dot_q;
		cand_n = cand_q;
		wlen_n = wlen_q;
		do_start = 1'b0;
		opp = sct_pkg::op_lookup(pend_q);
		opc = sct_pkg::op_lookup(ch);
		pk = sct_pkg::punct_kind(ch);

		// close or continue the open token
		case (mode_q)
			M_OP: begin
				if (!opp.found) begin
					do_start = 1'b1;
				end else if (ch == opp.e1) begin
					res[n[1:0]] = sct_pkg::mk_rec(opp.s1, line_q, col_q);
					n = n + 3'd1;
					mode_n = M_IDLE;
				end else if (opp.has_e2 && (ch == opp.e2)) begin
					res[n[1:0]] = sct_pkg::mk_rec(opp.s2, line_q, col_q);
					n = n + 3'd1;
					mode_n = M_IDLE;
				end else begin
					res[n[1:0]] = sct_pkg::mk_rec(opp.fail, sl_q, sc_q);
					n = n + 3'd1;
					do_start = 1'b1;
				end
			end
			M_DOT: begin
				if (sct_pkg::is_digit(ch)) begin
					res[0] = sct_pkg::mk_val(sct_pkg::CH_ZERO);
					res[1] = sct_pkg::mk_val(sct_pkg::CH_DOT);
					res[2] = sct_pkg::mk_val(ch);
					n = 3'd3;
					mode_n = M_NUM;
					dot_n = 1'b1;
					sl_n = line_q;
					sc_n = col_q;
				end else begin
					res[n[1:0]] = sct_pkg::mk_rec(sct_pkg::K_DOT, line_q, col_q);
					n = n + 3'd1;
					do_start = 1'b1;
				end
			end
			M_NUM: begin
				if (sct_pkg::is_digit(ch)) begin
					res[n[1:0]] = sct_pkg::mk_val(ch);
					n = n + 3'd1;
				end else if ((ch == sct_pkg::CH_DOT) && !dot_q) begin
					dot_n = 1'b1;
					res[n[1:0]] = sct_pkg::mk_val(ch);
					n = n + 3'd1;
				end else begin
					res[n[1:0]] = sct_pkg::mk_rec(dot_q ? sct_pkg::K_NUMBER : sct_pkg::K_INT,
						sl_q, sc_q);
					n = n + 3'd1;
					do_start = 1'b1;
				end
			end
			M_WORD: begin
				if (sct_pkg::is_digit(ch) || sct_pkg::is_alpha(ch)) begin
					cand_n = sct_pkg::word_cand(cand_q, wlen_q, ch);
					wlen_n = (wlen_q < 3'd7) ? wlen_q + 3'd1 : wlen_q;
					res[n[1:0]] = sct_pkg::mk_val(ch);
					n = n + 3'd1;
				end else begin
					res[n[1:0]] = sct_pkg::mk_rec(sct_pkg::is_kw(cand_q, wlen_q) ?
						sct_pkg::K_KEYWORD : sct_pkg::K_WORD, sl_q, sc_q);
					n = n + 3'd1;
					do_start = 1'b1;
				end
			end
			M_STR: begin
				if (ch == sct_pkg::CH_QUOTE) begin
					res[n[1:0]] = sct_pkg::mk_rec(sct_pkg::K_STRING, sl_q, sc_q);
					n = n + 3'd1;
					mode_n = M_IDLE;
				end else begin
					res[n[1:0]] = sct_pkg::mk_val(ch);
					n = n + 3'd1;
				end
			end
			default: do_start = 1'b1;
		endcase

		// begin a new token on this byte
		if (do_start) begin
			mode_n = M_IDLE;
			if ((ch == sct_pkg::CH_SPACE) || (ch == sct_pkg::CH_FF) ||
					(ch == sct_pkg::CH_LF) || (ch == sct_pkg::CH_CR)) begin
				mode_n = M_IDLE;
			end else if (pk.hit) begin
				res[n[1:0]] = sct_pkg::mk_rec(pk.kind, line_q, col_q);
				n = n + 3'd1;
			end else if (ch == sct_pkg::CH_DOT) begin
				mode_n = M_DOT;
				sl_n = line_q;
				sc_n = col_q;
			end else if (ch == sct_pkg::CH_QUOTE) begin
				mode_n = M_STR;
				sl_n = line_q;
				sc_n = col_q;
			end else if (opc.found) begin
				mode_n = M_OP;
				pend_n = ch;
				sl_n = line_q;
				sc_n = col_q;
			end else if (sct_pkg::is_digit(ch)) begin
				mode_n = M_NUM;
				dot_n = 1'b0;
				sl_n = line_q;
				sc_n = col_q;
				res[n[1:0]] = sct_pkg::mk_val(ch);
				n = n + 3'd1;
			end else if (sct_pkg::is_alpha(ch)) begin
				mode_n = M_WORD;
				cand_n = sct_pkg::word_cand(3'b111, 3'd0, ch);
				wlen_n = 3'd1;
				sl_n = line_q;
				sc_n = col_q;
				res[n[1:0]] = sct_pkg::mk_val(ch);
				n = n + 3'd1;
			end else begin
				res[n[1:0]] = sct_pkg::mk_val(ch);
				n = n + 3'd1;
				res[n[1:0]] = sct_pkg::mk_rec(sct_pkg::K_ERROR, line_q, col_q);
				n = n + 3'd1;
			end
		end

		// position of the next byte
		line_n = line_q;
		col_n = col_q;
		if (ch == sct_pkg::CH_LF) begin
			if (line_q != PMAX)
				line_n = line_q + 1'b1;
			col_n = '0;
		end else if (col_q != PMAX) begin
			col_n = col_q + 1'b1;
		end

		// end of source closes any open token and restarts the lexer
		opf = sct_pkg::op_lookup(pend_n);
		if (end_of_source) begin
			case (mode_n)
				M_OP: begin
					if (opf.found) begin
						res[n[1:0]] = sct_pkg::mk_rec(opf.fail, sl_n, sc_n);
						n = n + 3'd1;
					end
				end
				M_DOT: begin
					res[n[1:0]] = sct_pkg::mk_rec(sct_pkg::K_DOT, line_n, col_n);
					n = n + 3'd1;
				end
				M_NUM: begin
					res[n[1:0]] = sct_pkg::mk_rec(dot_n ? sct_pkg::K_NUMBER : sct_pkg::K_INT,
						sl_n, sc_n);
					n = n + 3'd1;
				end
				M_WORD: begin
					res[n[1:0]] = sct_pkg::mk_rec(sct_pkg::is_kw(cand_n, wlen_n) ?
						sct_pkg::K_KEYWORD : sct_pkg::K_WORD, sl_n, sc_n);
					n = n + 3'd1;
				end
				M_STR: begin
					res[n[1:0]] = sct_pkg::mk_rec(sct_pkg::K_STRING, sl_n, sc_n);
					n = n + 3'd1;
				end
				default: ;
			endcase
			mode_n = M_IDLE;
			pend_n = 8'h00;
			sl_n = '0;
			sc_n = '0;
			line_n = '0;
			col_n = '0;
			dot_n = 1'b0;
			cand_n = 3'b111;
			wlen_n = 3'd0;
		end

		if (n != 3'd0)
			res[n[1:0] - 2'd1].last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			pend_q <= 8'h00;
			sl_q <= '0;
			sc_q <= '0;
			line_q <= '0;
			col_q <= '0;
			dot_q <= 1'b0;
			cand_q <= 3'b111;
			wlen_q <= 3'd0;
		end else if (accept) begin
			mode_q <= mode_n;
			pend_q <= pend_n;
			sl_q <= sl_n;
			sc_q <= sc_n;
			line_q <= line_n;
			col_q <= col_n;
			dot_q <= dot_n;
			cand_q <= cand_n;
			wlen_q <= wlen_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (accept) begin
			cnt_q <= n;
		end else if (pop) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	// result queue, head at entry 0
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < sct_pkg::MAX_RES; i++)
				rbuf_q[i] <= res[i];
		end else if (pop) begin
			for (int i = 0; i < sct_pkg::MAX_RES - 1; i++)
				rbuf_q[i] <= rbuf_q[i+1];
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4)
		else $error("result queue count out of range");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && (cnt_q == 3'd1) |-> last_of_run)
		else $error("final queued result lacks last_of_run");

	a_eos_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && end_of_source |=> (mode_q == M_IDLE) && (line_q == '0) && (col_q == '0))
		else $error("lexer not restarted after end of source");

	a_word_len: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_WORD) |-> (wlen_q != 3'd0))
		else $error("word mode with empty word");

endmodule

// ===== tb/tb_source_char_tokenizer.sv =====
import sct_pkg::*;

class token_scoreboard;
	typedef enum logic [2:0] {LX_IDLE, LX_OP, LX_DOT, LX_NUM, LX_WORD, LX_STR} lex_mode_e;

	lex_mode_e   mode;
	logic [7:0]  pend_op;
	logic [15:0] tok_line;
	logic [15:0] tok_col;
	logic [15:0] cur_line;
	logic [15:0] cur_col;
	bit          frac;
	bit [2:0]    kw_live;
	bit [2:0]    kw_len_cnt;
	string       kw_txt[3];
	res_t        byte_words[$];
	res_t        token_words_due[$];
	int          errors;

	function new();
		kw_txt[0] = "const";
		kw_txt[1] = "True";
		kw_txt[2] = "False";
		errors = 0;
		restart();
	endfunction

	function void restart();
		mode = LX_IDLE;
		pend_op = 8'h00;
		tok_line = '0;
		tok_col = '0;
		cur_line = '0;
		cur_col = '0;
		frac = 1'b0;
		kw_live = 3'b111;
		kw_len_cnt = 3'd0;
	endfunction

	function void emit_value(logic [7:0] b);
		res_t r;
		r = '0;
		r.vbyte = b;
		if (byte_words.size() < MAX_RES)
			byte_words.push_back(r);
	endfunction

	function void emit_record(logic [5:0] k, logic [15:0] l, logic [15:0] c);
		res_t r;
		r = '0;
		r.is_record = 1'b1;
		r.kind = k;
		r.line = l;
		r.col = c;
		if (byte_words.size() < MAX_RES)
			byte_words.push_back(r);
	endfunction

	function bit op_rule(input logic [7:0] c, output logic [5:0] single,
			output logic [7:0] x1, output logic [5:0] k1, output bit has2,
			output logic [7:0] x2, output logic [5:0] k2);
		single = K_ERROR;
		x1 = "=";
		k1 = K_ERROR;
		has2 = 1'b0;
		x2 = 8'h00;
		k2 = K_ERROR;
		case (c)
			"<": begin
				single = K_LT; k1 = K_LE; has2 = 1'b1; x2 = "<"; k2 = K_SHL;
			end
			">": begin
				single = K_GT; k1 = K_GE; has2 = 1'b1; x2 = ">"; k2 = K_SHR;
			end
			"+": begin
				single = K_PLUS; x1 = "+"; k1 = K_INC; has2 = 1'b1; k2 = K_PLUS_EQ; x2 = "=";
			end
			"-": begin
				single = K_MINUS; x1 = "-"; k1 = K_DEC; has2 = 1'b1; k2 = K_MINUS_EQ; x2 = "=";
			end
			"&": begin
				single = K_AMP; x1 = "&"; k1 = K_LAND; has2 = 1'b1; k2 = K_AMP_EQ; x2 = "=";
			end
			"|": begin
				single = K_PIPE; x1 = "|"; k1 = K_LOR; has2 = 1'b1; k2 = K_PIPE_EQ; x2 = "=";
			end
			"^": begin
				single = K_XOR; k1 = K_XOR_EQ;
			end
			"*": begin
				single = K_STAR; k1 = K_STAR_EQ;
			end
			"/": begin
				single = K_SLASH; k1 = K_SLASH_EQ;
			end
			"%": begin
				single = K_PCT; k1 = K_PCT_EQ;
			end
			"=": begin
				single = K_ASSIGN; k1 = K_EQ;
			end
			"!": begin
				single = K_BANG; k1 = K_NE;
			end
			default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	function bit punct_of(input logic [7:0] c, output logic [5:0] k);
		k = K_ERROR;
		case (c)
			"(": k = K_LBRACKET;
			")": k = K_RBRACKET;
			"[": k = K_LSQUARE;
			"]": k = K_RSQUARE;
			"{": k = K_LCURLY;
			"}": k = K_RCURLY;
			":": k = K_COLON;
			";": k = K_SEMI;
			",": k = K_COMMA;
			"?": k = K_QUESTION;
			"#": k = K_HASH;
			"@": k = K_AT;
			"$": k = K_DOLLAR;
			"~": k = K_NOT;
			default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	function bit digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function bit alpha(logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
	endfunction

	function void mark();
		tok_line = cur_line;
		tok_col = cur_col;
	endfunction

	function void word_push(logic [7:0] c);
		for (int k = 0; k < 3; k++) begin
			if (kw_live[k] && (kw_len_cnt >= kw_txt[k].len() || kw_txt[k][kw_len_cnt] != c))
				kw_live[k] = 1'b0;
		end
		if (kw_len_cnt < 3'd7)
			kw_len_cnt++;
		emit_value(c);
	endfunction

	function void word_close();
		logic [5:0] k;
		k = K_WORD;
		for (int i = 0; i < 3; i++) begin
			if (kw_live[i] && kw_txt[i].len() == kw_len_cnt)
				k = K_KEYWORD;
		end
		emit_record(k, tok_line, tok_col);
	endfunction

	function void begin_token(logic [7:0] c);
		logic [5:0] pk;
		logic [5:0] s;
		logic [5:0] k1;
		logic [5:0] k2;
		logic [7:0] x1;
		logic [7:0] x2;
		bit h2;
		mode = LX_IDLE;
		if (c == CH_SPACE || c == CH_FF || c == CH_LF || c == CH_CR)
			return;
		if (c == CH_DOT) begin
			mode = LX_DOT;
			mark();
			return;
		end
		if (c == CH_QUOTE) begin
			mode = LX_STR;
			mark();
			return;
		end
		if (punct_of(c, pk)) begin
			emit_record(pk, cur_line, cur_col);
			return;
		end
		if (op_rule(c, s, x1, k1, h2, x2, k2)) begin
			mode = LX_OP;
			pend_op = c;
			mark();
		end else if (digit(c)) begin
			mode = LX_NUM;
			frac = 1'b0;
			mark();
			emit_value(c);
		end else if (alpha(c)) begin
			mode = LX_WORD;
			kw_live = 3'b111;
			kw_len_cnt = 3'd0;
			mark();
			word_push(c);
		end else begin
			emit_value(c);
			emit_record(K_ERROR, cur_line, cur_col);
		end
	endfunction

	function void lex_byte(logic [7:0] c);
		logic [5:0] s;
		logic [5:0] k1;
		logic [5:0] k2;
		logic [7:0] x1;
		logic [7:0] x2;
		bit h2;
		case (mode)
			LX_OP: begin
				void'(op_rule(pend_op, s, x1, k1, h2, x2, k2));
				if (c == x1) begin
					emit_record(k1, cur_line, cur_col);
					mode = LX_IDLE;
				end else if (h2 && c == x2) begin
					emit_record(k2, cur_line, cur_col);
					mode = LX_IDLE;
				end else begin
					// lookahead rejected: operator keeps its own position
					emit_record(s, tok_line, tok_col);
					begin_token(c);
				end
			end
			LX_DOT: begin
				if (digit(c)) begin
					emit_value(CH_ZERO);
					emit_value(CH_DOT);
					emit_value(c);
					mode = LX_NUM;
					frac = 1'b1;
					mark();
				end else begin
					emit_record(K_DOT, cur_line, cur_col);
					begin_token(c);
				end
			end
			LX_NUM: begin
				if (digit(c)) begin
					emit_value(c);
				end else if (c == CH_DOT && !frac) begin
					frac = 1'b1;
					emit_value(c);
				end else begin
					emit_record(frac ? K_NUMBER : K_INT, tok_line, tok_col);
					begin_token(c);
				end
			end
			LX_WORD: begin
				if (digit(c) || alpha(c)) begin
					word_push(c);
				end else begin
					word_close();
					begin_token(c);
				end
			end
			LX_STR: begin
				if (c == CH_QUOTE) begin
					emit_record(K_STRING, tok_line, tok_col);
					mode = LX_IDLE;
				end else begin
					emit_value(c);
				end
			end
			default: begin_token(c);
		endcase
	endfunction

	function void close_source();
		logic [5:0] s;
		logic [5:0] k1;
		logic [5:0] k2;
		logic [7:0] x1;
		logic [7:0] x2;
		bit h2;
		case (mode)
			LX_OP: begin
				if (op_rule(pend_op, s, x1, k1, h2, x2, k2))
					emit_record(s, tok_line, tok_col);
			end
			LX_DOT: emit_record(K_DOT, cur_line, cur_col);
			LX_NUM: emit_record(frac ? K_NUMBER : K_INT, tok_line, tok_col);
			LX_WORD: word_close();
			LX_STR: emit_record(K_STRING, tok_line, tok_col);
			default: ;
		endcase
	endfunction

	function void add_source_byte(logic [7:0] c, bit eos);
		byte_words.delete();
		lex_byte(c);
		if (c == CH_LF) begin
			if (cur_line != 16'hFFFF)
				cur_line++;
			cur_col = '0;
		end else if (cur_col != 16'hFFFF) begin
			cur_col++;
		end
		if (eos) begin
			close_source();
			restart();
		end
		if (byte_words.size() > 0)
			byte_words[byte_words.size() - 1].last = 1'b1;
		foreach (byte_words[i])
			token_words_due.push_back(byte_words[i]);
	endfunction

	function void cmp_field(string name, int unsigned e, int unsigned a);
		if (e != a) begin
			errors++;
			$display("%0t: %s expected %0h actual %0h", $time, name, e, a);
		end
	endfunction

	function void compare_token_word(logic rec, logic [5:0] kind, logic [15:0] line,
			logic [15:0] col, logic [7:0] vb, logic last);
		res_t e;
		if (token_words_due.size() == 0) begin
			errors++;
			$display("%0t: word with none expected, actual rec %0h kind %0d line %0h",
				$time, rec, kind, line);
			$display("%0t:   col %0h byte %0h last %0h", $time, col, vb, last);
			return;
		end
		e = token_words_due.pop_front();
		cmp_field("is_record", e.is_record, rec);
		cmp_field("token_kind", e.kind, kind);
		cmp_field("line_no", e.line, line);
		cmp_field("column_no", e.col, col);
		cmp_field("value_byte", e.vbyte, vb);
		cmp_field("last_of_run", e.last, last);
	endfunction

	function int pending();
		return token_words_due.size();
	endfunction
endclass

module tb_source_char_tokenizer;
	typedef enum int {RX_FREE, RX_SPARSE, RX_EVERY3, RX_COIN} sink_mode_e;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        src_valid;
	logic        src_ready;
	logic [7:0]  ch;
	logic        end_of_source;
	logic        tok_valid;
	logic        tok_ready;
	logic        is_record;
	logic [5:0]  token_kind;
	logic [15:0] line_no;
	logic [15:0] column_no;
	logic [7:0]  value_byte;
	logic        last_of_run;

	token_scoreboard sb;
	logic [7:0]  text_q[$];
	int          burst_left = 0;
	int          random_items = 0;
	int          rx_left = 0;
	sink_mode_e  rx_mode = RX_FREE;
	bit          hold_off_req = 1'b0;
	bit          hold_done = 1'b0;
	string       alpha_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
	string       digit_set = "0123456789";
	string       op_set = "<>+-&|^*/%=!";
	string       follow_set = "=<>+-&|";
	string       punct_set = "()[]{}:;,?#@$~";
	string       space_set = " \014\015\n";

	source_char_tokenizer u_top (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#4000000;
		$display("FAIL");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (src_valid && src_ready)
				sb.add_source_byte(ch, end_of_source);
			if (tok_valid && tok_ready)
				sb.compare_token_word(is_record, token_kind, line_no, column_no, value_byte,
					last_of_run);
		end
	end

	// output side: changing stall pattern, one long hold-off on request
	initial begin
		tok_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req && !hold_done) begin
				hold_done = 1'b1;
				tok_ready <= 1'b0;
				repeat (400) @(posedge clk);
			end
			if (rx_left == 0) begin
				rx_mode = sink_mode_e'($urandom_range(0, 3));
				rx_left = $urandom_range(16, 80);
			end
			rx_left--;
			case (rx_mode)
				RX_FREE: tok_ready <= 1'b1;
				RX_SPARSE: tok_ready <= ($urandom_range(0, 3) != 0);
				RX_EVERY3: tok_ready <= (rx_left % 3 == 0);
				default: tok_ready <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	function automatic logic [7:0] pick(string s);
		return s[$urandom_range(0, s.len() - 1)];
	endfunction

	task automatic push_text(string s);
		for (int i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
	endtask

	task automatic send_word(input logic [7:0] c, input bit eos);
		src_valid <= 1'b1;
		ch <= c;
		end_of_source <= eos;
		do @(posedge clk); while (!src_ready);
	endtask

	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		gap = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 15) : $urandom_range(0, 3);
		if (gap > 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_left = $urandom_range(0, 30);
	endtask

	task automatic send_text(input bit eos_last);
		foreach (text_q[i]) begin
			send_word(text_q[i], eos_last && (i == text_q.size() - 1));
			pace();
		end
		text_q.delete();
	endtask

	task automatic add_token();
		int n;
		n = $urandom_range(1, 10);
		case ($urandom_range(0, 15))
			0: begin
				case ($urandom_range(0, 2))
					0: push_text("const");
					1: push_text("True");
					default: push_text("False");
				endcase
			end
			1: begin
				case ($urandom_range(0, 5))
					0: push_text("cons");
					1: push_text("const7");
					2: push_text("Tru");
					3: push_text("Trues");
					4: push_text("Falsely");
					default: push_text("constantly");
				endcase
			end
			2: begin
				text_q.push_back(pick(alpha_set));
				repeat (n - 1)
					text_q.push_back(($urandom_range(0, 3) == 0) ? pick(digit_set) : pick(alpha_set));
			end
			3: repeat ($urandom_range(1, 4)) text_q.push_back(pick(digit_set));
			4: begin
				repeat ($urandom_range(1, 3)) text_q.push_back(pick(digit_set));
				text_q.push_back(CH_DOT);
				repeat ($urandom_range(0, 3)) text_q.push_back(pick(digit_set));
			end
			5: begin
				text_q.push_back(CH_DOT);
				repeat ($urandom_range(1, 3)) text_q.push_back(pick(digit_set));
			end
			6: text_q.push_back(CH_DOT);
			7, 8: begin
				text_q.push_back(pick(op_set));
				if ($urandom_range(0, 2) != 0)
					text_q.push_back(pick(follow_set));
			end
			9: text_q.push_back(pick(punct_set));
			10: begin
				text_q.push_back(CH_QUOTE);
				repeat ($urandom_range(0, 6)) begin
					text_q.push_back(8'($urandom_range(8'h23, 8'h7E)));
				end
				if ($urandom_range(0, 9) != 0)
					text_q.push_back(CH_QUOTE);
			end
			11: begin
				text_q.push_back(CH_QUOTE);
				repeat ($urandom_range(0, 5)) text_q.push_back(8'($urandom_range(8'h80, 8'hFF)));
				repeat ($urandom_range(0, 2)) text_q.push_back(8'($urandom_range(8'h00, 8'h21)));
				text_q.push_back(CH_QUOTE);
			end
			12: text_q.push_back(pick(space_set));
			13: begin
				case ($urandom_range(0, 5))
					0: text_q.push_back(8'h00);
					1: text_q.push_back(8'h09);
					2: text_q.push_back(8'($urandom_range(8'h80, 8'hFF)));
					3: text_q.push_back(8'($urandom_range(8'h01, 8'h08)));
					4: text_q.push_back(8'h7F);
					default: push_text("\\`'");
				endcase
			end
			14: text_q.push_back(8'($urandom_range(0, 255)));
			default: push_text("1.2.3");
		endcase
		if ($urandom_range(0, 1) == 0)
			text_q.push_back(pick(space_set));
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		src_valid = 1'b0;
		ch = 8'h00;
		end_of_source = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// keyword, two-char operator, lone dot at end of source
		push_text("False\nx>=.");
		send_text(1'b1);
		// unterminated string
		push_text("\"ab");
		send_text(1'b1);
		// error bytes, then number with a second dot
		text_q = '{8'hFF, 8'h00, 8'h09, 8'h80};
		push_text("1.2.");
		send_text(1'b1);
		// operator pending at end of source
		push_text("-");
		send_text(1'b1);

		while (random_items < 190) begin
			repeat ($urandom_range(4, 14)) add_token();
			if (random_items > 100 && !hold_off_req)
				hold_off_req <= 1'b1;
			random_items += text_q.size();
			send_text($urandom_range(0, 3) != 0);
		end

		// open word at the end of the last source
		push_text("(x y");
		send_text(1'b1);
		src_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
